@@ rtl/core/ppq_pkg.sv @@
package ppq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int COUNT_FIELD_W = 5;

   typedef enum logic [1:0] {
      ACT_ENQUEUE = 2'd0,
      ACT_PICK    = 2'd1,
      ACT_STEAL   = 2'd2,
      ACT_NOP     = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STAT_DONE    = 2'd0,
      STAT_IGNORED = 2'd1,
      STAT_FULL    = 2'd2,
      STAT_EMPTY   = 2'd3
   } status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   typedef struct packed {
      logic load;   // capture the request fields
      logic exec;   // apply the request and load the response register
   } cmd_type;

   typedef struct packed {
      logic [7:0]               task_id;
      logic [7:0]               task_prio;
      logic                     runnable;
      logic                     task_is_idle;
   } req_fields_type;

   typedef struct packed {
      status_type               status;
      logic [7:0]               out_task_id;
      logic [7:0]               out_task_prio;
      logic                     resched_req;
      logic [COUNT_FIELD_W-1:0] queue_count;
   } rsp_fields_type;

endpackage

@@ rtl/core/ppq_ctrl.sv @@
module ppq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output ppq_pkg::cmd_type cmd
);
   import ppq_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd.load     = 1'b0;
      cmd.exec     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // wait until the response register is free
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.exec     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

`ifndef NO_ASSERTIONS
   a_exec_when_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC && !rsp_valid_ff) |=> (state_ff == ST_IDLE && rsp_valid_ff))
      else $error("pending request not executed into a free response slot");
   a_no_accept_in_exec: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) |-> !cmd.load)
      else $error("request captured while one is still in work");
`endif

endmodule

@@ rtl/core/ppq_datapath.sv @@
module ppq_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  ppq_pkg::cmd_type        cmd,
   input  ppq_pkg::action_type     req_action,
   input  ppq_pkg::req_fields_type req_fields,
   input  logic                    preempt_en,
   output ppq_pkg::rsp_fields_type rsp_fields
);
   import ppq_pkg::*;

   // captured request
   action_type     act_ff;
   req_fields_type fld_ff;

   // sorted slots, slot 0 is the head; slots at or above count hold stale data
   logic [7:0] task_ff [QUEUE_DEPTH];
   logic [7:0] task_in [QUEUE_DEPTH];
   logic [7:0] prio_ff [QUEUE_DEPTH];
   logic [7:0] prio_in [QUEUE_DEPTH];

   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       run_task_ff, run_task_in;
   logic [7:0]       run_prio_ff, run_prio_in;
   logic             run_valid_ff, run_valid_in;
   logic             front_mark_ff, front_mark_in;
   logic             resched_ff, resched_in;
   rsp_fields_type   rsp_ff, rsp_in;

   logic [QUEUE_DEPTH-1:0] occupied;
   logic [QUEUE_DEPTH-1:0] stay;
   logic                   hit;
   logic                   full;
   logic                   empty;
   logic                   front;
   logic [IDX_W-1:0]       tail_idx;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff <= req_action;
         fld_ff <= req_fields;
      end
      if (cmd.exec) begin
         task_ff <= task_in;
         prio_ff <= prio_in;
         rsp_ff  <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         run_task_ff   <= '0;
         run_prio_ff   <= '0;
         run_valid_ff  <= 1'b0;
         front_mark_ff <= 1'b0;
         resched_ff    <= 1'b0;
      end else if (cmd.exec) begin
         count_ff      <= count_in;
         run_task_ff   <= run_task_in;
         run_prio_ff   <= run_prio_in;
         run_valid_ff  <= run_valid_in;
         front_mark_ff <= front_mark_in;
         resched_ff    <= resched_in;
      end
   end

   // per-slot compares, all in parallel
   always_comb begin
      front = run_valid_ff && front_mark_ff && (fld_ff.task_id == run_task_ff);
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         occupied[i] = (CNT_W'(i) < count_ff);
         // slot keeps its place when it sorts ahead of the new task
         stay[i] = occupied[i] && (front ? (prio_ff[i] < fld_ff.task_prio)
                                         : (prio_ff[i] <= fld_ff.task_prio));
      end
      hit = 1'b0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (occupied[i] && task_ff[i] == fld_ff.task_id) begin
            hit = 1'b1;
         end
      end
   end

   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign tail_idx = IDX_W'(count_ff - CNT_W'(1));

   always_comb begin
      task_in       = task_ff;
      prio_in       = prio_ff;
      count_in      = count_ff;
      run_task_in   = run_task_ff;
      run_prio_in   = run_prio_ff;
      run_valid_in  = run_valid_ff;
      front_mark_in = front_mark_ff;
      resched_in    = resched_ff;
      rsp_in.status        = STAT_DONE;
      rsp_in.out_task_id   = '0;
      rsp_in.out_task_prio = '0;

      case (act_ff)
         ACT_ENQUEUE: begin
            if (fld_ff.task_is_idle || hit) begin
               rsp_in.status = STAT_IGNORED;
            end else if (full) begin
               rsp_in.status = STAT_FULL;
            end else begin
               for (int i = 0; i < QUEUE_DEPTH; i++) begin
                  if (!stay[i]) begin
                     if (i == 0 || stay[(i == 0) ? 0 : i - 1]) begin
                        task_in[i] = fld_ff.task_id;
                        prio_in[i] = fld_ff.task_prio;
                     end else begin
                        task_in[i] = task_ff[(i == 0) ? 0 : i - 1];
                        prio_in[i] = prio_ff[(i == 0) ? 0 : i - 1];
                     end
                  end
               end
               count_in = count_ff + CNT_W'(1);
               if (front) begin
                  front_mark_in = 1'b0;
               end
               if (!fld_ff.runnable && preempt_en && run_valid_ff &&
                   (fld_ff.task_prio < run_prio_ff)) begin
                  resched_in    = 1'b1;
                  front_mark_in = 1'b1;
               end
            end
         end
         ACT_PICK: begin
            resched_in = 1'b0;
            if (empty) begin
               rsp_in.status = STAT_EMPTY;
            end else begin
               rsp_in.out_task_id   = task_ff[0];
               rsp_in.out_task_prio = prio_ff[0];
               for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                  task_in[i] = task_ff[i + 1];
                  prio_in[i] = prio_ff[i + 1];
               end
               count_in      = count_ff - CNT_W'(1);
               run_task_in   = task_ff[0];
               run_prio_in   = prio_ff[0];
               run_valid_in  = 1'b1;
               front_mark_in = 1'b0;
            end
         end
         ACT_STEAL: begin
            if (empty) begin
               rsp_in.status = STAT_EMPTY;
            end else begin
               rsp_in.out_task_id   = task_ff[tail_idx];
               rsp_in.out_task_prio = prio_ff[tail_idx];
               count_in = count_ff - CNT_W'(1);
            end
         end
         ACT_NOP: begin
         end
         default: begin
         end
      endcase

      rsp_in.resched_req = resched_in;
      rsp_in.queue_count = COUNT_FIELD_W'(count_in);
   end

   assign rsp_fields = rsp_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> (count_ff == $past(count_ff) || count_ff == $past(count_ff) + CNT_W'(1)
                    || count_ff + CNT_W'(1) == $past(count_ff)))
      else $error("queue count moved by more than one");
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !cmd.exec |=> ($stable(count_ff) && $stable(resched_ff) && $stable(run_valid_ff)))
      else $error("queue state changed without a request");
   a_pick_clears: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && act_ff == ACT_PICK) |=> (!resched_ff && (empty || !front_mark_ff)))
      else $error("pick left a reschedule request or front mark");
`endif

endmodule

@@ rtl/core/preemptive_priority_ready_queue.sv @@
// Preemptive priority ready queue.
// Requests enter on the req_ stream: tuser selects enqueue, nop, pick (take the
// head) or steal (take the tail); tdata carries the task and its priority (lower
// is more urgent). Every request gives exactly one response on the rsp_ stream
// with a status code, the removed task, the reschedule flag and the queue count.
// A request is captured, then applied to the sorted shift queue once the
// response register is free; every slot compares against the new priority in
// parallel and shifts by one place. The response is registered; no new request
// is taken until the last is applied. When the receiver stalls, the result
// waits in the response register; the next request is still captured and held
// until that register frees. Reset empties the queue, clears the running task,
// the reschedule flag and the preemption enable. preemption_enable sits at
// byte address 0 of the csr_ port; write it only while no request is in work.
module preemptive_priority_ready_queue (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // task_id[7:0], task_prio[15:8], runnable[16],
                                   // task_is_idle[17], zero[23:18]
   input  logic [1:0]  req_tuser,  // action[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // out_task_id[7:0], out_task_prio[15:8],
                                   // resched_req[16], queue_count[21:17], zero[23:22]
   output logic [1:0]  rsp_tuser,  // status[1:0]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import ppq_pkg::*;

   localparam logic REG_PREEMPT_EN = 1'b0;

   logic           preempt_en_ff;
   cmd_type        cmd;
   req_fields_type req_fields;
   rsp_fields_type rsp_fields;
   logic           csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         preempt_en_ff <= 1'b0;
      end else if (csr_write && csr_paddr[2] == REG_PREEMPT_EN) begin
         preempt_en_ff <= csr_pwdata[0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_PREEMPT_EN) ? {31'b0, preempt_en_ff} : 32'b0;

   assign req_fields.task_id      = req_tdata[7:0];
   assign req_fields.task_prio    = req_tdata[15:8];
   assign req_fields.runnable     = req_tdata[16];
   assign req_fields.task_is_idle = req_tdata[17];

   ppq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   ppq_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_action (action_type'(req_tuser)),
      .req_fields (req_fields),
      .preempt_en (preempt_en_ff),
      .rsp_fields (rsp_fields)
   );

   assign rsp_tuser = rsp_fields.status;
   assign rsp_tdata = {2'b00, rsp_fields.queue_count, rsp_fields.resched_req,
                       rsp_fields.out_task_prio, rsp_fields.out_task_id};

endmodule

@@ tb/tb_preemptive_priority_ready_queue.sv @@
module tb_preemptive_priority_ready_queue;
   timeunit 1ns;
   timeprecision 1ps;

   import ppq_pkg::*;

   localparam logic [2:0] CSR_PREEMPTION_ENABLE = 3'd0;
   localparam int DIRECTED_ROWS = 25;
   localparam int RANDOM_PHASES = 10;
   localparam int ITEMS_PER_PHASE = 100;

   typedef enum logic {
      ROW_REQUEST   = 1'b0,
      ROW_CSR_WRITE = 1'b1
   } row_kind_type;

   typedef struct packed {
      row_kind_type   kind;
      logic           cfg_value;
      action_type     act;
      logic [7:0]     task_id;
      logic [7:0]     task_prio;
      logic           runnable;
      logic           task_is_idle;
      logic [4:0]     reps;       // consecutive task ids, 0 means one request
      logic           typed;
      rsp_fields_type want;
   } step_row_type;

   localparam rsp_fields_type EMPTY_AT_RESET   = '{STAT_EMPTY, 8'd0, 8'd0, 1'b0, 5'd0};
   localparam rsp_fields_type NOP_AT_RESET     = '{STAT_DONE, 8'd0, 8'd0, 1'b0, 5'd0};
   localparam rsp_fields_type IGNORED_AT_RESET = '{STAT_IGNORED, 8'd0, 8'd0, 1'b0, 5'd0};
   localparam rsp_fields_type NO_RESULT        = '0;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // scoreboard model of the ready queue
   logic [7:0]  slot_task_m [QUEUE_DEPTH];
   logic [7:0]  slot_prio_m [QUEUE_DEPTH];
   int          queued = 0;
   logic [7:0]  run_id_m = '0;
   logic [7:0]  cur_prio = '0;
   logic        cur_valid = 1'b0;
   logic        cur_goes_front = 1'b0;
   logic        resched = 1'b0;
   logic        preempt_en = 1'b0;

   rsp_fields_type awaited_responses[$];
   int          error_count = 0;
   int          stall_left = 0;
   bit          quiet = 1'b0;

   step_row_type directed_rows [DIRECTED_ROWS];

   preemptive_priority_ready_queue uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   function automatic rsp_fields_type ready_queue_step(input action_type act,
                                                       input logic [7:0] id,
                                                       input logic [7:0] prio,
                                                       input logic runnable,
                                                       input logic idle);
      rsp_fields_type r;
      bit found;
      bit front;
      int pos;
      int i;
      r = '0;
      r.status = STAT_DONE;
      case (act)
         ACT_ENQUEUE: begin
            found = 1'b0;
            for (i = 0; i < queued; i++)
               if (slot_task_m[i] == id)
                  found = 1'b1;
            if (idle || found) begin
               r.status = STAT_IGNORED;
            end else if (queued >= QUEUE_DEPTH) begin
               r.status = STAT_FULL;
            end else begin
               // a preempted running task goes back ahead of its equals
               front = cur_valid && cur_goes_front && id == run_id_m;
               if (front)
                  cur_goes_front = 1'b0;
               pos = 0;
               while (pos < queued &&
                      (front ? slot_prio_m[pos] < prio : slot_prio_m[pos] <= prio))
                  pos++;
               for (i = queued; i > pos; i--) begin
                  slot_task_m[i] = slot_task_m[i-1];
                  slot_prio_m[i] = slot_prio_m[i-1];
               end
               slot_task_m[pos] = id;
               slot_prio_m[pos] = prio;
               queued++;
               if (!runnable && preempt_en && cur_valid && prio < cur_prio) begin
                  resched = 1'b1;
                  cur_goes_front = 1'b1;
               end
            end
         end
         ACT_PICK: begin
            resched = 1'b0;
            if (queued == 0) begin
               r.status = STAT_EMPTY;
            end else begin
               r.out_task_id = slot_task_m[0];
               r.out_task_prio = slot_prio_m[0];
               for (i = 0; i + 1 < queued; i++) begin
                  slot_task_m[i] = slot_task_m[i+1];
                  slot_prio_m[i] = slot_prio_m[i+1];
               end
               queued--;
               run_id_m = r.out_task_id;
               cur_prio = r.out_task_prio;
               cur_valid = 1'b1;
               cur_goes_front = 1'b0;
            end
         end
         ACT_STEAL: begin
            if (queued == 0) begin
               r.status = STAT_EMPTY;
            end else begin
               r.out_task_id = slot_task_m[queued-1];
               r.out_task_prio = slot_prio_m[queued-1];
               queued--;
            end
         end
         default: begin
         end
      endcase
      r.resched_req = resched;
      r.queue_count = queued[4:0];
      return r;
   endfunction

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   task automatic send_request(input action_type act, input logic [7:0] id,
                               input logic [7:0] prio, input logic runnable,
                               input logic idle, input bit use_want,
                               input rsp_fields_type want);
      rsp_fields_type predicted;
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 6);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= {6'b0, idle, runnable, prio, id};
      do @(posedge clock); while (!req_tready);
      predicted = ready_queue_step(act, id, prio, runnable, idle);
      awaited_responses.push_back(use_want ? want : predicted);
   endtask

   // hold off requests until every response is back
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (awaited_responses.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_preemption_enable(input logic value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_PREEMPTION_ENABLE;
      csr_pwdata <= {31'b0, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      preempt_en = value;
      // read it back
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      check_field("preemption_enable readback", {31'b0, value}, csr_prdata);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // response side backpressure
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      rsp_fields_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_responses.size() == 0) begin
            error_count++;
            $display("%0t: unexpected response, expected none, got status %0d task %0d",
                     $time, rsp_tuser, rsp_tdata[7:0]);
         end else begin
            want = awaited_responses.pop_front();
            check_field("status", want.status, rsp_tuser);
            check_field("out_task_id", want.out_task_id, rsp_tdata[7:0]);
            check_field("out_task_prio", want.out_task_prio, rsp_tdata[15:8]);
            check_field("resched_req", want.resched_req, rsp_tdata[16]);
            check_field("queue_count", want.queue_count, rsp_tdata[21:17]);
         end
         stall_left = quiet ? 0 : $urandom_range(0, 6);
      end
   end

   initial begin
      step_row_type row;
      action_type   act;
      logic [7:0]   id;
      logic [7:0]   prio;
      int r;
      int k;
      int phase;
      int counted;
      int enq_pct;
      int roll;

      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = ACT_NOP;
      rsp_tready = 1'b1;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = CSR_PREEMPTION_ENABLE;
      csr_pwdata = '0;

      directed_rows = '{
         '{ROW_CSR_WRITE, 1'b1, ACT_NOP,     8'd0,   8'd0,   1'b0, 1'b0, 5'd0,  1'b0, NO_RESULT},
         '{ROW_REQUEST,   1'b0, ACT_PICK,    8'd0,   8'd0,   1'b0, 1'b0, 5'd0,  1'b1,
           EMPTY_AT_RESET},
         '{ROW_REQUEST,   1'b0, ACT_STEAL,   8'd0,   8'd0,   1'b0, 1'b0, 5'd0,  1'b1,
           EMPTY_AT_RESET},
         '{ROW_REQUEST,   1'b0, ACT_NOP,     8'd255, 8'd255, 1'b1, 1'b1, 5'd0,  1'b1,
           NOP_AT_RESET},
         '{ROW_REQUEST,   1'b0, ACT_ENQUEUE, 8'd5,   8'd1,   1'b0, 1'b1, 5'd0,  1'b1,
           IGNORED_AT_RESET},
         // woken with nothing running: no reschedule
         '{ROW_REQUEST,   1'b0, ACT_ENQUEUE, 8'd20,  8'd100, 1'b0, 1'b0, 5'd0,  1'b0, NO_RESULT},
         '{ROW_REQUEST,   1'b0, ACT_PICK,    8'd0,   8'd0,   1'b0, 1'b0, 5'd0,  1'b0, NO_RESULT},
         '{ROW_REQUEST,   1'b0, ACT_ENQUEUE, 8'd0,   8'd255, 1'b0, 1'b0, 5'd0,  1'b0, NO_RESULT},
         '{ROW_CSR_WRITE, 1'b0, ACT_NOP,     8'd0,   8'd0,   1'b0, 1'b0, 5'd0,  1'b0, NO_RESULT},
         '{ROW_REQUEST,   1'b0, ACT_ENQUEUE, 8'd255, 8'd0,   1'b0, 1'b0, 5'd0,  1'b0, NO_RESULT},
         '{ROW_REQUEST,   1'b0, ACT_ENQUEUE, 8'd10,  8'd0,   1'b1, 1'b0, 5'd0,  1'b0, NO_RESULT},
         '{ROW_REQUEST,   1'b0, ACT_ENQUEUE, 8'd10,  8'd3,   1'b0, 1'b0, 5'd0,  1'b0, NO_RESULT},
         '{ROW_CSR_WRITE, 1'b1, ACT_NOP,     8'd0,   8'd0,   1'b0, 1'b0, 5'd0,  1'b0, NO_RESULT},
         '{ROW_REQUEST,   1'b0, ACT_ENQUEUE, 8'd40,  8'd100, 1'b1, 1'b0, 5'd0,  1'b0, NO_RESULT},
         // preempts task 20, which then goes back ahead of task 40
         '{ROW_REQUEST,   1'b0, ACT_ENQUEUE, 8'd30,  8'd50,  1'b0, 1'b0, 5'd0,  1'b0, NO_RESULT},
         '{ROW_REQUEST,   1'b0, ACT_ENQUEUE, 8'd20,  8'd100, 1'b1, 1'b0, 5'd0,  1'b0, NO_RESULT},
         '{ROW_REQUEST,   1'b0, ACT_ENQUEUE, 8'd50,  8'd99,  1'b1, 1'b0, 5'd0,  1'b0, NO_RESULT},
         '{ROW_REQUEST,   1'b0, ACT_PICK,    8'd0,   8'd0,   1'b0, 1'b0, 5'd0,  1'b0, NO_RESULT},
         '{ROW_REQUEST,   1'b0, ACT_STEAL,   8'd0,   8'd0,   1'b0, 1'b0, 5'd0,  1'b0, NO_RESULT},
         '{ROW_REQUEST,   1'b0, ACT_ENQUEUE, 8'd60,  8'd200, 1'b0, 1'b0, 5'd0,  1'b0, NO_RESULT},
         '{ROW_REQUEST,   1'b0, ACT_ENQUEUE, 8'd100, 8'd7,   1'b1, 1'b0, 5'd10, 1'b0, NO_RESULT},
         // queue full now
         '{ROW_REQUEST,   1'b0, ACT_ENQUEUE, 8'd200, 8'd0,   1'b0, 1'b0, 5'd0,  1'b0, NO_RESULT},
         '{ROW_REQUEST,   1'b0, ACT_ENQUEUE, 8'd10,  8'd0,   1'b1, 1'b0, 5'd0,  1'b0, NO_RESULT},
         '{ROW_REQUEST,   1'b0, ACT_PICK,    8'd0,   8'd0,   1'b0, 1'b0, 5'd0,  1'b0, NO_RESULT},
         '{ROW_CSR_WRITE, 1'b0, ACT_NOP,     8'd0,   8'd0,   1'b0, 1'b0, 5'd0,  1'b0, NO_RESULT}
      };

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (r = 0; r < DIRECTED_ROWS; r++) begin
         row = directed_rows[r];
         if (row.kind == ROW_CSR_WRITE) begin
            wait_idle();
            write_preemption_enable(row.cfg_value);
         end else begin
            for (k = 0; k < ((row.reps == 0) ? 1 : row.reps); k++)
               send_request(row.act, row.task_id + k[7:0], row.task_prio, row.runnable,
                            row.task_is_idle, row.typed, row.want);
         end
      end

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_idle();
         write_preemption_enable((phase < 2) ? phase[0] : 1'($urandom_range(0, 1)));
         quiet = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 2))
            0: enq_pct = 50;
            1: enq_pct = 80;   // fills the queue
            default: enq_pct = 25;
         endcase
         counted = 0;
         while (counted < ITEMS_PER_PHASE) begin
            roll = $urandom_range(0, 99);
            if (roll < 3)
               act = ACT_NOP;
            else if (roll < enq_pct)
               act = ACT_ENQUEUE;
            else if (roll < enq_pct + (100 - enq_pct) * 3 / 5)
               act = ACT_PICK;
            else
               act = ACT_STEAL;
            // small id pool and narrow priorities give duplicates and ties
            case ($urandom_range(0, 7))
               0: id = run_id_m;
               1, 2, 3, 4: id = 8'($urandom_range(0, 23));
               default: id = 8'($urandom_range(0, 255));
            endcase
            prio = $urandom_range(0, 1) ? 8'($urandom_range(0, 15))
                                        : 8'($urandom_range(0, 255));
            send_request(act, id, prio, 1'($urandom_range(0, 1)),
                         ($urandom_range(0, 15) == 0), 1'b0, NO_RESULT);
            counted++;
            if ($urandom_range(0, 199) == 0)
               wait_idle();
         end
      end

      wait_idle();
      repeat (6) @(posedge clock);
      if (error_count == 0)
         $display("preemptive_priority_ready_queue test passed");
      else
         $display("preemptive_priority_ready_queue test failed");
      $finish;
   end

   initial begin
      #400000;
      $display("preemptive_priority_ready_queue test failed");
      $finish;
   end

endmodule
